// File: rtl/ffsa_pkg.sv
package ffsa_pkg;

  localparam int VAL_W = 32;

  typedef logic signed [VAL_W-1:0] node_val_t;

  typedef logic [1:0] op_t;

  localparam op_t OP_LOAD  = 2'd0;
  localparam op_t OP_PLACE = 2'd1;
  localparam op_t OP_CLEAR = 2'd2;

  // empty slot mark, all ones in two's complement
  localparam node_val_t EMPTY_VAL = '1;

  localparam logic [15:0] MISS_MAX = 16'hFFFF;

endpackage

// File: rtl/ffsa_ram.sv
module ffsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/first_fit_slot_allocator.sv
// First-fit slot allocator over a binary max tree held in one RAM.
//
// Command channel: an item (operation, slot_index, amount) is taken at a
// rising edge where start is high and busy is low. Each item gives exactly
// one result: done is high for one cycle with placed, chosen_slot and
// unplaced_count. The receiver cannot stall; done is a pulse.
//
// Load: writes the leaf, then rewrites the maxima on the path to the root,
// one tree level per cycle over the LEVELS = clog2(SLOTS) levels above the
// leaf. A load past the last slot, or unused code 3, just answers.
// Request: reads the root, descends one level per cycle taking the left
// child when it can hold the request, empties the leaf and climbs back.
// The single read port of the tree RAM sets this pace. A miss answers
// right after the root read.
// Clear: sweeps every tree node to the empty mark, one node per cycle,
// and zeroes the miss count.
// Reset: the same sweep runs with busy high and no done.
// The block works on one item at a time; start may come in the done cycle.
module first_fit_slot_allocator #(
  parameter int SLOTS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation,
  input  logic [9:0]  slot_index,
  input  logic [30:0] amount,
  output logic        done,
  output logic        placed,
  output logic [9:0]  chosen_slot,
  output logic [15:0] unplaced_count
);

  localparam int LEVELS = $clog2(SLOTS);
  localparam int LEAF   = 1 << LEVELS;
  localparam int DEPTH  = 2 * LEAF;
  localparam int NW     = LEVELS + 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ROOT  = 3'd1;
  localparam logic [2:0] S_DOWN  = 3'd2;
  localparam logic [2:0] S_LEAFW = 3'd3;
  localparam logic [2:0] S_UP    = 3'd4;
  localparam logic [2:0] S_CLEAR = 3'd5;

  localparam logic [NW-1:0] ROOT_NODE = NW'(1);
  localparam logic [NW-1:0] ROOT_LEFT = NW'(2);

  logic [2:0]              state;
  logic [NW-1:0]           node;     // current tree node
  logic [NW-1:0]           cnt;      // clear sweep address
  ffsa_pkg::node_val_t     v;        // value going up the path
  logic [30:0]             amt;      // requested size
  logic                    report;   // sweep belongs to a clear item
  logic                    found;
  logic [9:0]              slot_q;
  logic [15:0]             miss;

  logic                    we;
  logic [NW-1:0]           waddr;
  ffsa_pkg::node_val_t     wdata;
  logic [NW-1:0]           raddr;
  logic [ffsa_pkg::VAL_W-1:0] rdata;

  ffsa_pkg::node_val_t     rd_s;
  logic                    fits;
  logic [NW-1:0]           child;
  ffsa_pkg::node_val_t     v_up;
  logic [31:0]             slot_wide;
  logic [31:0]             leaf_slot;

  ffsa_ram #(
    .WIDTH(ffsa_pkg::VAL_W),
    .DEPTH(DEPTH)
  ) u_tree (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign rd_s  = ffsa_pkg::node_val_t'(rdata);
  // request fits below the node just read
  assign fits  = rd_s >= $signed({1'b0, amt});
  assign child = {node[NW-2:0], ~fits};
  assign v_up  = (rd_s > v) ? rd_s : v;

  assign slot_wide = 32'(slot_index);
  assign leaf_slot = 32'(node[NW-2:0]);

  // read address: root while idle, left child on the way down,
  // sibling on the way up
  always_comb begin
    case (state)
      S_IDLE:  raddr = ROOT_NODE;
      S_ROOT:  raddr = ROOT_LEFT;
      S_DOWN:  raddr = {child[NW-2:0], 1'b0};
      S_LEAFW: raddr = node ^ ROOT_NODE;
      S_UP:    raddr = node ^ ROOT_NODE;
      default: raddr = ROOT_NODE;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = node;
    wdata = v;
    case (state)
      S_LEAFW: begin
        we = 1'b1;
      end
      S_UP: begin
        we    = 1'b1;
        wdata = v_up;
      end
      S_CLEAR: begin
        we    = 1'b1;
        waddr = cnt;
        wdata = ffsa_pkg::EMPTY_VAL;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_CLEAR;
      cnt    <= '0;
      report <= 1'b0;
      done   <= 1'b0;
      miss   <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            amt    <= amount;
            found  <= 1'b0;
            slot_q <= '0;
            case (operation)
              ffsa_pkg::OP_PLACE: begin
                state <= S_ROOT;
              end
              ffsa_pkg::OP_CLEAR: begin
                miss   <= '0;
                cnt    <= '0;
                report <= 1'b1;
                state  <= S_CLEAR;
              end
              default: begin
                // load; code 3 answers like a load that writes nothing
                if (operation == ffsa_pkg::OP_LOAD && slot_wide < 32'(SLOTS)) begin
                  node  <= NW'(32'(LEAF) + slot_wide);
                  v     <= ffsa_pkg::node_val_t'({1'b0, amount});
                  state <= S_LEAFW;
                end else begin
                  done  <= 1'b1;
                  state <= S_IDLE;
                end
              end
            endcase
          end
        end
        S_ROOT: begin
          if (fits) begin
            node  <= ROOT_NODE;
            state <= S_DOWN;
          end else begin
            if (miss != ffsa_pkg::MISS_MAX) begin
              miss <= miss + 16'd1;
            end
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_DOWN: begin
          node <= child;
          if (child[NW-1]) begin
            v      <= ffsa_pkg::EMPTY_VAL;
            found  <= 1'b1;
            state  <= S_LEAFW;
          end
        end
        S_LEAFW: begin
          if (found) begin
            slot_q <= leaf_slot[9:0];
          end
          node  <= node >> 1;
          state <= S_UP;
        end
        S_UP: begin
          if (node == ROOT_NODE) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            v    <= v_up;
            node <= node >> 1;
          end
        end
        S_CLEAR: begin
          cnt <= cnt + NW'(1);
          if (cnt == NW'(DEPTH - 1)) begin
            done   <= report;
            report <= 1'b0;
            state  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign busy           = (state != S_IDLE);
  assign placed         = found;
  assign chosen_slot    = slot_q;
  assign unplaced_count = miss;

endmodule
